// ----- sv/property_frame_codec_assert.svh -----
// ----------------------------------------------------------------------------
// property_frame_codec assertion macros
// clocked by clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PROPERTY_FRAME_CODEC_ASSERT_SVH
`define PROPERTY_FRAME_CODEC_ASSERT_SVH

// same-cycle implication
`define PFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg
// types, codes and property layout for the property frame codec
// ----------------------------------------------------------------------------
package pfc_pkg;

	typedef enum logic [1:0] {
		CMD_RX_BYTE = 2'd0,
		CMD_SEND    = 2'd1,
		CMD_WRITE   = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_TX        = 2'd0,
		KIND_RX_STATUS = 2'd1,
		KIND_LOCAL     = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_SHORT = 3'd1,
		ST_BAD_HDR   = 3'd2,
		ST_UNKNOWN   = 3'd3,
		ST_BAD_SUM   = 3'd4,
		ST_RANGE     = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_COPY,
		S_RX_DONE,
		S_RDWAIT,
		S_HDR,
		S_SRD,
		S_SDAT,
		S_SCHK
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic        last;
		status_t     status;
	} rsp_t;

	localparam logic [7:0] SYNC0         = 8'hAA;
	localparam logic [7:0] SYNC1         = 8'hBB;
	localparam logic [3:0] PROP_CODE_MAX = 4'd8;
	localparam int         HDR_BYTES     = 4;
	localparam int         MIN_FRAME     = 6;

	// byte offset of a property in the store, t is code minus one
	function automatic int prop_base(input logic [2:0] t, input int loc);
		int b;
		case (t)
			3'd0:    b = 0;
			3'd1:    b = 1;
			3'd2:    b = 2;
			3'd3:    b = 2 + loc;
			3'd4:    b = 4 + loc;
			3'd5:    b = 6 + loc;
			3'd6:    b = 7 + loc;
			default: b = 8 + loc;
		endcase
		return b;
	endfunction

	function automatic int prop_size(input logic [2:0] t, input int loc);
		int s;
		case (t) inside
			3'd2:          s = loc;
			3'd3, 3'd4:    s = 2;
			default:       s = 1;
		endcase
		return s;
	endfunction

	// power-up contents of the store
	function automatic logic [7:0] init_value(input int addr, input int loc);
		logic [7:0] v;
		v = 8'h00;
		if (addr == 0)
			v = 8'h01;
		else if (addr == 1)
			v = 8'h64;
		else if (addr == loc + 2)
			v = 8'h12;
		else if (addr == loc + 3)
			v = 8'h34;
		else if (addr == loc + 4)
			v = 8'h56;
		else if (addr == loc + 5)
			v = 8'h78;
		else if (addr == loc + 6)
			v = 8'h32;
		else if (addr == loc + 7)
			v = 8'h20;
		else if (addr == loc + 8)
			v = 8'h05;
		return v;
	endfunction

endpackage

// ----- sv/pfc_if.sv -----
// ----------------------------------------------------------------------------
// pfc_if
// request and response channels of the property frame codec
// ----------------------------------------------------------------------------
interface pfc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;
	logic       frame_end;
	logic [3:0] property_type;
	logic [4:0] byte_offset;

	modport source (output valid, command, data_byte, frame_end, property_type,
		byte_offset, input ready);
	modport sink (input valid, command, data_byte, frame_end, property_type,
		byte_offset, output ready);
endinterface

interface pfc_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       last;
	logic [2:0] status;

	modport source (output valid, kind, out_byte, last, status, input ready);
	modport sink (input valid, kind, out_byte, last, status, output ready);
endinterface

// ----- sv/pfc_ram.sv -----
// ----------------------------------------------------------------------------
// pfc_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- sv/property_frame_codec.sv -----
// ----------------------------------------------------------------------------
// property_frame_codec
// property store with framed byte link: send, receive, local write and read
// ----------------------------------------------------------------------------
// usage
//   req carries one item per handshake: a received link byte, a send
//   request, a local write or a local read. rsp returns the result items
//   through a single output register; the item that ends each command has
//   last set. cfg_wr_en/cfg_wr_data load the receive checksum enable.
// operation
//   received byte without frame end: no result
//   frame end: one status result, once any payload bytes are committed
//   (stage ram read then store ram write, one byte a cycle, then status)
//   local write and any rejected command: one result
//   local read: one result, after the registered store ram read
//   send: four header bytes, then per payload byte a store read and then
//   an output load, then one checksum byte; the store ram read paces the bytes
//   one item is worked at a time; req.ready is low while one is in progress
// reset
//   after arst_n rises the store is loaded with its power-up contents,
//   all 9 + LOCATION_BYTES bytes, with req.ready low
// stalls
//   a held rsp item freezes the sequencer; a new item is still taken in the
//   cycle the waiting result leaves
// ----------------------------------------------------------------------------
module property_frame_codec #(
	parameter int LOCATION_BYTES = 32,
	parameter int RX_FRAME_MAX   = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	pfc_req_if.sink   req,
	pfc_rsp_if.source rsp
);

	localparam int STORE_BYTES = 9 + LOCATION_BYTES;
	localparam int SA_W  = $clog2(STORE_BYTES);
	localparam int SG_AW = $clog2(LOCATION_BYTES);
	localparam int SZ_W  = $clog2(LOCATION_BYTES + 1);
	localparam int CNT_W = $clog2(RX_FRAME_MAX + 1);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	// sequencer and output register
	pfc_pkg::state_t state_q, state_n;
	logic            out_v_q;
	pfc_pkg::rsp_t   out_q, out_n;
	logic            load_out;
	logic            slot_free;
	logic            accept;
	logic            check_sum_q;

	// store ram ports
	logic            st_we, st_re;
	logic [SA_W-1:0] st_waddr, st_raddr;
	logic [7:0]      st_wdata, st_rdata;

	// payload stage ram ports
	logic             sg_we, sg_re;
	logic [SG_AW-1:0] sg_waddr, sg_raddr;
	logic [7:0]       sg_rdata;

	// receive frame state
	logic [CNT_W-1:0] rx_count_q, rx_count_n;
	logic             rx_hdr_ok_q, rx_hdr_ok_n;
	logic [7:0]       rx_type_q, rx_type_n;
	logic [7:0]       rx_len_q, rx_len_n;
	logic [7:0]       rx_xor_q, rx_xor_n;
	logic [7:0]       rx_last_q, rx_last_n;
	logic             rx_in_frame;
	logic [CNT_W-1:0] rx_pos;
	logic             stage_hit;
	logic             rx_type_ok;
	logic [2:0]       rx_t;
	logic [SZ_W-1:0]  rx_size;
	logic [SA_W-1:0]  rx_base;
	logic [SZ_W-1:0]  rx_copy_n;
	pfc_pkg::status_t rx_status;
	logic             rx_go_copy;

	// commit of a good frame into the store
	logic [SZ_W-1:0]  copy_i_q, copy_n_q;
	logic [SA_W-1:0]  copy_base_q;
	logic [CNT_W-1:0] copy_lim_q;
	logic             copy_issue;
	logic             copy_v_s1;
	logic [SA_W-1:0]  copy_waddr_s1;
	logic             copy_zero_s1;

	// command decode
	pfc_pkg::cmd_t    cmd;
	logic             cmd_type_ok;
	logic [2:0]       cmd_t3;
	logic [SZ_W-1:0]  cmd_size;
	logic [SA_W-1:0]  cmd_base;
	logic             cmd_off_bad;

	// send sequencer
	logic [3:0]       send_type_q;
	logic [SZ_W-1:0]  send_size_q, send_i_q;
	logic [SA_W-1:0]  send_base_q;
	logic [7:0]       send_x_q;
	logic [1:0]       hdr_i_q;
	logic             send_last_dat;

	// power-up fill
	logic [SA_W-1:0]  init_i_q;
	logic             init_done;

	assign slot_free = !out_v_q || rsp.ready;
	assign req.ready = (state_q == pfc_pkg::S_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;
	assign init_done = (init_i_q == SA_W'(STORE_BYTES - 1));

	assign rsp.valid    = out_v_q;
	assign rsp.kind     = out_q.kind;
	assign rsp.out_byte = out_q.out_byte;
	assign rsp.last     = out_q.last;
	assign rsp.status   = out_q.status;

	// ------------------------------------------------------------------
	// command decode: property code and offset checks
	// ------------------------------------------------------------------
	always_comb begin
		cmd         = pfc_pkg::cmd_t'(req.command);
		cmd_type_ok = (req.property_type != 4'd0) &&
			(req.property_type <= pfc_pkg::PROP_CODE_MAX);
		cmd_t3      = 3'(req.property_type - 4'd1);
		cmd_size    = SZ_W'(pfc_pkg::prop_size(cmd_t3, LOCATION_BYTES));
		cmd_base    = SA_W'(pfc_pkg::prop_base(cmd_t3, LOCATION_BYTES));
		cmd_off_bad = ({3'b000, req.byte_offset} >= 8'(cmd_size));
	end

	// ------------------------------------------------------------------
	// receive path: fold one link byte into the frame state
	// ------------------------------------------------------------------
	always_comb begin
		rx_count_n  = rx_count_q;
		rx_hdr_ok_n = rx_hdr_ok_q;
		rx_type_n   = rx_type_q;
		rx_len_n    = rx_len_q;
		rx_xor_n    = rx_xor_q;
		rx_last_n   = rx_last_q;
		stage_hit   = 1'b0;
		rx_in_frame = (rx_count_q < CNT_W'(RX_FRAME_MAX));
		rx_pos      = rx_count_q - CNT_W'(pfc_pkg::HDR_BYTES);
		// bytes past the frame limit are dropped
		if (rx_in_frame) begin
			rx_count_n = rx_count_q + CNT_W'(1);
			if (rx_count_q == CNT_W'(0)) begin
				rx_hdr_ok_n = (req.data_byte == pfc_pkg::SYNC0);
			end else if (rx_count_q == CNT_W'(1)) begin
				rx_hdr_ok_n = rx_hdr_ok_q && (req.data_byte == pfc_pkg::SYNC1);
			end else if (rx_count_q == CNT_W'(2)) begin
				rx_type_n = req.data_byte;
				rx_xor_n  = rx_xor_q ^ req.data_byte;
			end else if (rx_count_q == CNT_W'(3)) begin
				rx_len_n = req.data_byte;
				rx_xor_n = rx_xor_q ^ req.data_byte;
			end else begin
				stage_hit = (rx_pos < CNT_W'(LOCATION_BYTES));
				if (CMP_W'(rx_pos) < CMP_W'(rx_len_q))
					rx_xor_n = rx_xor_q ^ req.data_byte;
				else if (CMP_W'(rx_pos) == CMP_W'(rx_len_q))
					rx_last_n = req.data_byte;
			end
		end

		rx_type_ok = (rx_type_n != 8'd0) && (rx_type_n <= 8'(pfc_pkg::PROP_CODE_MAX));
		rx_t       = 3'(rx_type_n - 8'd1);
		rx_size    = SZ_W'(pfc_pkg::prop_size(rx_t, LOCATION_BYTES));
		rx_base    = SA_W'(pfc_pkg::prop_base(rx_t, LOCATION_BYTES));
		rx_copy_n  = (CMP_W'(rx_len_n) > CMP_W'(rx_size)) ? rx_size : SZ_W'(rx_len_n);

		// frame checks in priority order
		if (rx_count_n < CNT_W'(pfc_pkg::MIN_FRAME))
			rx_status = pfc_pkg::ST_TOO_SHORT;
		else if (!rx_hdr_ok_n)
			rx_status = pfc_pkg::ST_BAD_HDR;
		else if (!rx_type_ok)
			rx_status = pfc_pkg::ST_UNKNOWN;
		else if (check_sum_q && (rx_xor_n != rx_last_n))
			rx_status = pfc_pkg::ST_BAD_SUM;
		else
			rx_status = pfc_pkg::ST_OK;
		rx_go_copy = (rx_status == pfc_pkg::ST_OK) && (rx_copy_n != SZ_W'(0));
	end

	assign copy_issue    = (state_q == pfc_pkg::S_COPY) && (copy_i_q < copy_n_q);
	assign send_last_dat = (SZ_W'(send_i_q + SZ_W'(1)) == send_size_q);

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	always_comb begin
		state_n = state_q;
		unique case (state_q) inside
			pfc_pkg::S_INIT: begin
				if (init_done)
					state_n = pfc_pkg::S_IDLE;
			end
			pfc_pkg::S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						pfc_pkg::CMD_RX_BYTE: begin
							if (req.frame_end && rx_go_copy)
								state_n = pfc_pkg::S_COPY;
						end
						pfc_pkg::CMD_SEND: begin
							if (cmd_type_ok)
								state_n = pfc_pkg::S_HDR;
						end
						pfc_pkg::CMD_READ: begin
							if (cmd_type_ok && !cmd_off_bad)
								state_n = pfc_pkg::S_RDWAIT;
						end
						default: state_n = pfc_pkg::S_IDLE;
					endcase
				end
			end
			pfc_pkg::S_COPY: begin
				if ((copy_i_q == copy_n_q) && !copy_v_s1)
					state_n = pfc_pkg::S_RX_DONE;
			end
			pfc_pkg::S_RX_DONE, pfc_pkg::S_RDWAIT, pfc_pkg::S_SCHK: begin
				if (slot_free)
					state_n = pfc_pkg::S_IDLE;
			end
			pfc_pkg::S_HDR: begin
				if (slot_free && (hdr_i_q == 2'd3))
					state_n = pfc_pkg::S_SRD;
			end
			pfc_pkg::S_SRD: state_n = pfc_pkg::S_SDAT;
			pfc_pkg::S_SDAT: begin
				if (slot_free)
					state_n = send_last_dat ? pfc_pkg::S_SCHK : pfc_pkg::S_SRD;
			end
			default: state_n = pfc_pkg::S_INIT;
		endcase
	end

	// ------------------------------------------------------------------
	// outputs: ram controls and output register load
	// ------------------------------------------------------------------
	always_comb begin
		load_out = 1'b0;
		out_n    = '{kind: pfc_pkg::KIND_LOCAL, out_byte: 8'h00, last: 1'b1,
			status: pfc_pkg::ST_OK};
		st_we    = 1'b0;
		st_waddr = init_i_q;
		st_wdata = pfc_pkg::init_value(int'(init_i_q), LOCATION_BYTES);
		st_re    = 1'b0;
		st_raddr = cmd_base + SA_W'(req.byte_offset);
		sg_we    = 1'b0;
		sg_waddr = rx_pos[SG_AW-1:0];
		sg_re    = copy_issue;
		sg_raddr = copy_i_q[SG_AW-1:0];
		unique case (state_q)
			pfc_pkg::S_INIT: st_we = 1'b1;
			pfc_pkg::S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						pfc_pkg::CMD_RX_BYTE: begin
							sg_we = stage_hit;
							if (req.frame_end && !rx_go_copy) begin
								load_out     = 1'b1;
								out_n.kind   = pfc_pkg::KIND_RX_STATUS;
								out_n.status = rx_status;
							end
						end
						default: begin
							if (!cmd_type_ok) begin
								load_out     = 1'b1;
								out_n.status = pfc_pkg::ST_UNKNOWN;
							end else if (cmd == pfc_pkg::CMD_SEND) begin
								load_out = 1'b0;
							end else if (cmd_off_bad) begin
								load_out     = 1'b1;
								out_n.status = pfc_pkg::ST_RANGE;
							end else if (cmd == pfc_pkg::CMD_WRITE) begin
								st_we    = 1'b1;
								st_waddr = cmd_base + SA_W'(req.byte_offset);
								st_wdata = req.data_byte;
								load_out = 1'b1;
							end else begin
								st_re = 1'b1;
							end
						end
					endcase
				end
			end
			pfc_pkg::S_COPY: begin
				st_we    = copy_v_s1;
				st_waddr = copy_waddr_s1;
				// stage positions not received this frame read as zero
				st_wdata = copy_zero_s1 ? 8'h00 : sg_rdata;
			end
			pfc_pkg::S_RX_DONE: begin
				load_out   = slot_free;
				out_n.kind = pfc_pkg::KIND_RX_STATUS;
			end
			pfc_pkg::S_RDWAIT: begin
				load_out       = slot_free;
				out_n.out_byte = st_rdata;
			end
			pfc_pkg::S_HDR: begin
				load_out   = slot_free;
				out_n.kind = pfc_pkg::KIND_TX;
				out_n.last = 1'b0;
				case (hdr_i_q)
					2'd0:    out_n.out_byte = pfc_pkg::SYNC0;
					2'd1:    out_n.out_byte = pfc_pkg::SYNC1;
					2'd2:    out_n.out_byte = {4'h0, send_type_q};
					default: out_n.out_byte = 8'(send_size_q);
				endcase
			end
			pfc_pkg::S_SRD: begin
				st_re    = 1'b1;
				st_raddr = send_base_q + SA_W'(send_i_q);
			end
			pfc_pkg::S_SDAT: begin
				load_out       = slot_free;
				out_n.kind     = pfc_pkg::KIND_TX;
				out_n.last     = 1'b0;
				out_n.out_byte = st_rdata;
			end
			pfc_pkg::S_SCHK: begin
				load_out       = slot_free;
				out_n.kind     = pfc_pkg::KIND_TX;
				out_n.out_byte = send_x_q;
			end
			default: load_out = 1'b0;
		endcase
	end

	// ------------------------------------------------------------------
	// control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfc_pkg::S_INIT;
			out_v_q     <= 1'b0;
			check_sum_q <= 1'b0;
			init_i_q    <= '0;
			rx_count_q  <= '0;
			rx_hdr_ok_q <= 1'b0;
			rx_type_q   <= '0;
			rx_len_q    <= '0;
			rx_xor_q    <= '0;
			rx_last_q   <= '0;
			copy_i_q    <= '0;
			copy_v_s1   <= 1'b0;
			hdr_i_q     <= '0;
			send_i_q    <= '0;
		end else begin
			state_q <= state_n;
			if (load_out)
				out_v_q <= 1'b1;
			else if (rsp.ready)
				out_v_q <= 1'b0;
			if (cfg_wr_en)
				check_sum_q <= cfg_wr_data;
			if (state_q == pfc_pkg::S_INIT)
				init_i_q <= init_i_q + SA_W'(1);

			// frame state clears as soon as the frame end is taken
			if (accept && (cmd == pfc_pkg::CMD_RX_BYTE)) begin
				if (req.frame_end) begin
					rx_count_q  <= '0;
					rx_hdr_ok_q <= 1'b0;
					rx_type_q   <= '0;
					rx_len_q    <= '0;
					rx_xor_q    <= '0;
					rx_last_q   <= '0;
					copy_i_q    <= '0;
				end else begin
					rx_count_q  <= rx_count_n;
					rx_hdr_ok_q <= rx_hdr_ok_n;
					rx_type_q   <= rx_type_n;
					rx_len_q    <= rx_len_n;
					rx_xor_q    <= rx_xor_n;
					rx_last_q   <= rx_last_n;
				end
			end

			copy_v_s1 <= copy_issue;
			if (copy_issue)
				copy_i_q <= copy_i_q + SZ_W'(1);

			if (accept && (cmd == pfc_pkg::CMD_SEND)) begin
				hdr_i_q  <= '0;
				send_i_q <= '0;
			end
			if ((state_q == pfc_pkg::S_HDR) && slot_free)
				hdr_i_q <= hdr_i_q + 2'd1;
			if ((state_q == pfc_pkg::S_SDAT) && slot_free)
				send_i_q <= send_i_q + SZ_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= out_n;
		if (accept && (cmd == pfc_pkg::CMD_RX_BYTE) && req.frame_end) begin
			copy_n_q    <= rx_copy_n;
			copy_base_q <= rx_base;
			copy_lim_q  <= rx_count_n - CNT_W'(pfc_pkg::HDR_BYTES);
		end
		copy_waddr_s1 <= copy_base_q + SA_W'(copy_i_q);
		copy_zero_s1  <= (CNT_W'(copy_i_q) >= copy_lim_q);
		if (accept && (cmd == pfc_pkg::CMD_SEND)) begin
			send_type_q <= req.property_type;
			send_size_q <= cmd_size;
			send_base_q <= cmd_base;
			send_x_q    <= {4'h0, req.property_type} ^ 8'(cmd_size);
		end
		if ((state_q == pfc_pkg::S_SDAT) && slot_free)
			send_x_q <= send_x_q ^ st_rdata;
	end

	// ------------------------------------------------------------------
	// memories
	// ------------------------------------------------------------------
	pfc_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	pfc_ram #(
		.WIDTH(8),
		.DEPTH(LOCATION_BYTES)
	) u_stage (
		.clk  (clk),
		.we   (sg_we),
		.waddr(sg_waddr),
		.wdata(req.data_byte),
		.re   (sg_re),
		.raddr(sg_raddr),
		.rdata(sg_rdata)
	);

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
`include "property_frame_codec_assert.svh"

	`PFC_ASSERT_NOW(a_init_blocks_req, state_q == pfc_pkg::S_INIT, !req.ready, "item taken during store fill")
	`PFC_ASSERT_NOW(a_rx_count_bound, 1'b1, rx_count_q <= CNT_W'(RX_FRAME_MAX), "frame count past limit")
	`PFC_ASSERT_NOW(a_copy_in_store, copy_v_s1 && state_q == pfc_pkg::S_COPY, copy_waddr_s1 < SA_W'(STORE_BYTES), "commit outside store")
	`PFC_ASSERT_NEXT(a_checksum_ends_send, state_q == pfc_pkg::S_SCHK && slot_free, state_q == pfc_pkg::S_IDLE && out_v_q && out_q.last, "send did not close")

endmodule
